[rtl/clh_pkg.sv]
`timescale 1ns / 1ps

package clh_pkg;

    // Field widths
    localparam int ENERGY_W    = 12;
    localparam int TIME_W      = 40;
    localparam int SEL_W       = 14;
    localparam int COUNT_W     = 32;
    localparam int LIMIT_W     = 17;
    localparam int APB_ADDR_W  = 6;
    localparam int APB_DATA_W  = 64;

    // Parameter defaults
    localparam int DEFAULT_NUM_BINS     = 16384;
    localparam int DEFAULT_BIN_WIDTH_PS = 5;

    // Output queue depth, also the limit on transactions in flight
    localparam int FIFO_DEPTH = 8;

    // Register indexes (byte address = 8 * index)
    localparam logic [2:0] REG_WINDOW_A_LOW      = 3'd0;
    localparam logic [2:0] REG_WINDOW_A_HIGH     = 3'd1;
    localparam logic [2:0] REG_WINDOW_B_LOW      = 3'd2;
    localparam logic [2:0] REG_WINDOW_B_HIGH     = 3'd3;
    localparam logic [2:0] REG_TIME_WINDOW       = 3'd4;
    localparam logic [2:0] REG_HISTOGRAM_LIMIT   = 3'd5;

    // Register reset values
    localparam logic [ENERGY_W-1:0] RST_WINDOW_A_LOW    = 12'd180;
    localparam logic [ENERGY_W-1:0] RST_WINDOW_A_HIGH   = 12'd390;
    localparam logic [ENERGY_W-1:0] RST_WINDOW_B_LOW    = 12'd660;
    localparam logic [ENERGY_W-1:0] RST_WINDOW_B_HIGH   = 12'd1100;
    localparam logic [TIME_W-1:0]   RST_TIME_WINDOW     = 40'd200000;
    localparam logic [LIMIT_W-1:0]  RST_HISTOGRAM_LIMIT = 17'd50000;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // One result transaction
    typedef struct packed {
        logic               accepted;
        logic [TIME_W-1:0]  abs_difference;
        logic               binned;
        logic [SEL_W-1:0]   bin_index;
        logic [COUNT_W-1:0] bin_count;
        logic [COUNT_W-1:0] accepted_total;
        logic [COUNT_W-1:0] rejected_total;
    } out_item_t;

    // Saturating increment
    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
        sat_inc = (v == COUNT_MAX) ? v : v + 1'b1;
    endfunction

    // Energy strictly inside either window
    function automatic logic in_windows(
        input logic [ENERGY_W-1:0] e,
        input logic [ENERGY_W-1:0] a_lo,
        input logic [ENERGY_W-1:0] a_hi,
        input logic [ENERGY_W-1:0] b_lo,
        input logic [ENERGY_W-1:0] b_hi
    );
        in_windows = ((e > a_lo) && (e < a_hi)) || ((e > b_lo) && (e < b_hi));
    endfunction

endpackage

[rtl/coincidence_lifetime_histogrammer.sv]
`timescale 1ns / 1ps

// Energy-windowed two-detector coincidence time histogram. One transaction
// (detector event or bin read) is accepted per cycle while in_ready is high;
// its result leaves an eight-entry output queue, and up to eight transactions
// may be in flight, so outside the clearing pass in_ready drops only when that
// many are unread. The four-stage pipeline reads the bin in stage three and
// writes the incremented count back in stage four, forwarding that count to
// the next transaction when it touches the same bin, so one memory port pair
// sets the one-per-cycle rate. After reset a clearing pass zeroes the
// histogram, one bin per cycle, with in_ready low; the configuration port is
// ready throughout. The bin is |dt| / BIN_WIDTH_PS, formed by a reciprocal
// multiply on the 17-bit difference.
module coincidence_lifetime_histogrammer #(
    parameter int NUM_BINS     = clh_pkg::DEFAULT_NUM_BINS,
    parameter int BIN_WIDTH_PS = clh_pkg::DEFAULT_BIN_WIDTH_PS
) (
    input  logic                              clk,
    input  logic                              rst_n,

    // Input channel
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              kind,
    input  logic                              hit_a,
    input  logic                              hit_b,
    input  logic [clh_pkg::ENERGY_W-1:0]      energy_a,
    input  logic [clh_pkg::ENERGY_W-1:0]      energy_b,
    input  logic [clh_pkg::TIME_W-1:0]        time_a,
    input  logic [clh_pkg::TIME_W-1:0]        time_b,
    input  logic [clh_pkg::SEL_W-1:0]         bin_select,

    // Output channel
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              accepted,
    output logic [clh_pkg::TIME_W-1:0]        abs_difference,
    output logic                              binned,
    output logic [clh_pkg::SEL_W-1:0]         bin_index,
    output logic [clh_pkg::COUNT_W-1:0]       bin_count,
    output logic [clh_pkg::COUNT_W-1:0]       accepted_total,
    output logic [clh_pkg::COUNT_W-1:0]       rejected_total,

    // Configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [clh_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [clh_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [clh_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);

    localparam int ADDR_W    = $clog2(NUM_BINS);
    localparam int DQ_W      = clh_pkg::LIMIT_W;          // width of binned difference
    localparam int SHIFT     = DQ_W + $clog2(BIN_WIDTH_PS);
    localparam int RECIP_W   = DQ_W + 2;
    localparam int PROD_W    = DQ_W + RECIP_W;
    localparam longint unsigned RECIP_FULL =
        ((64'd1 << SHIFT) + BIN_WIDTH_PS - 1) / BIN_WIDTH_PS;
    localparam logic [RECIP_W-1:0] RECIP_M   = RECIP_W'(RECIP_FULL);
    localparam logic [DQ_W:0]      BIN_LIMIT = (DQ_W + 1)'(NUM_BINS);
    localparam logic [ADDR_W-1:0]  LAST_BIN  = ADDR_W'(NUM_BINS - 1);
    localparam int PTR_W     = $clog2(clh_pkg::FIFO_DEPTH);
    localparam int CREDIT_W  = PTR_W + 1;
    localparam logic [CREDIT_W-1:0] FIFO_FULL = CREDIT_W'(clh_pkg::FIFO_DEPTH);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [clh_pkg::ENERGY_W-1:0] win_a_lo_reg, win_a_hi_reg, win_b_lo_reg, win_b_hi_reg;
    logic [clh_pkg::TIME_W-1:0]   time_window_reg;
    logic [clh_pkg::LIMIT_W-1:0]  hist_limit_reg;
    logic                         cfg_write;
    logic [2:0]                   cfg_index;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = paddr[5:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_a_lo_reg    <= clh_pkg::RST_WINDOW_A_LOW;
            win_a_hi_reg    <= clh_pkg::RST_WINDOW_A_HIGH;
            win_b_lo_reg    <= clh_pkg::RST_WINDOW_B_LOW;
            win_b_hi_reg    <= clh_pkg::RST_WINDOW_B_HIGH;
            time_window_reg <= clh_pkg::RST_TIME_WINDOW;
            hist_limit_reg  <= clh_pkg::RST_HISTOGRAM_LIMIT;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                clh_pkg::REG_WINDOW_A_LOW:    win_a_lo_reg    <= pwdata[clh_pkg::ENERGY_W-1:0];
                clh_pkg::REG_WINDOW_A_HIGH:   win_a_hi_reg    <= pwdata[clh_pkg::ENERGY_W-1:0];
                clh_pkg::REG_WINDOW_B_LOW:    win_b_lo_reg    <= pwdata[clh_pkg::ENERGY_W-1:0];
                clh_pkg::REG_WINDOW_B_HIGH:   win_b_hi_reg    <= pwdata[clh_pkg::ENERGY_W-1:0];
                clh_pkg::REG_TIME_WINDOW:     time_window_reg <= pwdata[clh_pkg::TIME_W-1:0];
                clh_pkg::REG_HISTOGRAM_LIMIT: hist_limit_reg  <= pwdata[clh_pkg::LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // Register readback
    always_comb
    begin
        unique case (cfg_index)
            clh_pkg::REG_WINDOW_A_LOW:    prdata = 64'(win_a_lo_reg);
            clh_pkg::REG_WINDOW_A_HIGH:   prdata = 64'(win_a_hi_reg);
            clh_pkg::REG_WINDOW_B_LOW:    prdata = 64'(win_b_lo_reg);
            clh_pkg::REG_WINDOW_B_HIGH:   prdata = 64'(win_b_hi_reg);
            clh_pkg::REG_TIME_WINDOW:     prdata = 64'(time_window_reg);
            clh_pkg::REG_HISTOGRAM_LIMIT: prdata = 64'(hist_limit_reg);
            default:                      prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Flow control: credit covers pipeline plus output queue
    // ------------------------------------------------------------------
    logic                clear_active_reg;
    logic [ADDR_W-1:0]   clear_addr_reg;
    logic [CREDIT_W-1:0] credit_reg, credit_next;
    logic [CREDIT_W-1:0] fifo_count_reg, fifo_count_next;
    logic                in_fire, out_fire;

    assign in_ready = !clear_active_reg && (credit_reg < FIFO_FULL);
    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid && out_ready;

    always_comb
    begin
        credit_next = credit_reg;
        if (in_fire && !out_fire)
            credit_next = credit_reg + 1'b1;
        else if (!in_fire && out_fire)
            credit_next = credit_reg - 1'b1;
    end

    // ------------------------------------------------------------------
    // Pipeline valids
    // ------------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, v4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_fire;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: captured transaction; difference and energy checks
    // ------------------------------------------------------------------
    logic                         kind1_reg, hit_a1_reg, hit_b1_reg;
    logic [clh_pkg::ENERGY_W-1:0] energy_a1_reg, energy_b1_reg;
    logic [clh_pkg::TIME_W-1:0]   time_a1_reg, time_b1_reg;
    logic [clh_pkg::SEL_W-1:0]    sel1_reg;
    logic [clh_pkg::TIME_W-1:0]   diff1;
    logic                         energy_ok1;

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            kind1_reg     <= kind;
            hit_a1_reg    <= hit_a;
            hit_b1_reg    <= hit_b;
            energy_a1_reg <= energy_a;
            energy_b1_reg <= energy_b;
            time_a1_reg   <= time_a;
            time_b1_reg   <= time_b;
            sel1_reg      <= bin_select;
        end
    end

    always_comb
    begin
        if (kind1_reg)
            diff1 = '0;
        else if (time_a1_reg >= time_b1_reg)
            diff1 = time_a1_reg - time_b1_reg;
        else
            diff1 = time_b1_reg - time_a1_reg;
    end

    assign energy_ok1 = hit_a1_reg && hit_b1_reg
        && clh_pkg::in_windows(energy_a1_reg, win_a_lo_reg, win_a_hi_reg,
                               win_b_lo_reg, win_b_hi_reg)
        && clh_pkg::in_windows(energy_b1_reg, win_a_lo_reg, win_a_hi_reg,
                               win_b_lo_reg, win_b_hi_reg);

    // ------------------------------------------------------------------
    // Stage 2: time window, histogram limit, reciprocal multiply
    // ------------------------------------------------------------------
    logic                         kind2_reg, energy_ok2_reg;
    logic [clh_pkg::TIME_W-1:0]   diff2_reg;
    logic [clh_pkg::SEL_W-1:0]    sel2_reg;
    logic                         ok2, lim2;
    logic [PROD_W-1:0]            prod2;

    always_ff @(posedge clk)
    begin
        kind2_reg      <= kind1_reg;
        energy_ok2_reg <= energy_ok1;
        diff2_reg      <= diff1;
        sel2_reg       <= sel1_reg;
    end

    assign ok2   = !kind2_reg && energy_ok2_reg && (diff2_reg < time_window_reg);
    assign lim2  = diff2_reg < clh_pkg::TIME_W'(hist_limit_reg);
    assign prod2 = PROD_W'(diff2_reg[DQ_W-1:0]) * PROD_W'(RECIP_M);

    // ------------------------------------------------------------------
    // Stage 3: bin index, range checks, memory read
    // ------------------------------------------------------------------
    logic                         kind3_reg, ok3_reg, lim3_reg;
    logic [clh_pkg::TIME_W-1:0]   diff3_reg;
    logic [PROD_W-1:0]            prod3_reg;
    logic [clh_pkg::SEL_W-1:0]    sel3_reg;
    logic [DQ_W-1:0]              quot3;
    logic [DQ_W-1:0]              addr3_full;
    logic                         binnable3, sel_ok3;
    logic [clh_pkg::SEL_W-1:0]    idx3;

    always_ff @(posedge clk)
    begin
        kind3_reg <= kind2_reg;
        ok3_reg   <= ok2;
        lim3_reg  <= lim2;
        diff3_reg <= diff2_reg;
        prod3_reg <= prod2;
        sel3_reg  <= sel2_reg;
    end

    assign quot3      = DQ_W'(prod3_reg >> SHIFT);
    assign binnable3  = ok3_reg && lim3_reg && ({1'b0, quot3} < BIN_LIMIT);
    assign sel_ok3    = {1'b0, DQ_W'(sel3_reg)} < BIN_LIMIT;
    assign addr3_full = kind3_reg ? DQ_W'(sel3_reg) : quot3;
    assign idx3       = kind3_reg ? sel3_reg
                      : (binnable3 ? quot3[clh_pkg::SEL_W-1:0] : '0);

    // ------------------------------------------------------------------
    // Stage 4: forward, increment, write back, counters
    // ------------------------------------------------------------------
    logic                         kind4_reg, acc4_reg, binnable4_reg, sel_ok4_reg;
    logic [clh_pkg::TIME_W-1:0]   diff4_reg;
    logic [ADDR_W-1:0]            addr4_reg;
    logic [clh_pkg::SEL_W-1:0]    idx4_reg;
    logic [clh_pkg::COUNT_W-1:0]  rd_data_reg;
    logic                         wr_valid_reg;
    logic [ADDR_W-1:0]            wr_addr_reg;
    logic [clh_pkg::COUNT_W-1:0]  wr_data_reg;
    logic [clh_pkg::COUNT_W-1:0]  cur4, inc4;
    logic                         item_we;
    logic [clh_pkg::COUNT_W-1:0]  acc_total_reg, acc_total_next;
    logic [clh_pkg::COUNT_W-1:0]  rej_total_reg, rej_total_next;
    clh_pkg::out_item_t           push_item;

    always_ff @(posedge clk)
    begin
        kind4_reg     <= kind3_reg;
        acc4_reg      <= ok3_reg;
        binnable4_reg <= binnable3;
        sel_ok4_reg   <= sel_ok3;
        diff4_reg     <= diff3_reg;
        addr4_reg     <= addr3_full[ADDR_W-1:0];
        idx4_reg      <= idx3;
    end

    assign cur4    = (wr_valid_reg && (wr_addr_reg == addr4_reg)) ? wr_data_reg : rd_data_reg;
    assign inc4    = clh_pkg::sat_inc(cur4);
    assign item_we = v4_reg && binnable4_reg;

    always_comb
    begin
        acc_total_next = acc_total_reg;
        rej_total_next = rej_total_reg;
        if (v4_reg && !kind4_reg)
        begin
            if (acc4_reg)
                acc_total_next = clh_pkg::sat_inc(acc_total_reg);
            else
                rej_total_next = clh_pkg::sat_inc(rej_total_reg);
        end
    end

    always_comb
    begin
        push_item.accepted       = acc4_reg;
        push_item.abs_difference = diff4_reg;
        push_item.binned         = binnable4_reg;
        push_item.bin_index      = idx4_reg;
        push_item.accepted_total = acc_total_next;
        push_item.rejected_total = rej_total_next;
        if (kind4_reg)
            push_item.bin_count = sel_ok4_reg ? cur4 : '0;
        else
            push_item.bin_count = binnable4_reg ? inc4 : '0;
    end

    // Last write, kept for forwarding to the following transaction
    always_ff @(posedge clk)
    begin
        wr_addr_reg <= addr4_reg;
        wr_data_reg <= inc4;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_valid_reg  <= 1'b0;
            acc_total_reg <= '0;
            rej_total_reg <= '0;
        end
        else
        begin
            wr_valid_reg  <= item_we;
            acc_total_reg <= acc_total_next;
            rej_total_reg <= rej_total_next;
        end
    end

    // ------------------------------------------------------------------
    // Histogram memory and clearing pass
    // ------------------------------------------------------------------
    logic [clh_pkg::COUNT_W-1:0] hist_mem [NUM_BINS];
    logic                        mem_we, mem_re;
    logic [ADDR_W-1:0]           mem_waddr;
    logic [clh_pkg::COUNT_W-1:0] mem_wdata;

    assign mem_we    = clear_active_reg || item_we;
    assign mem_waddr = clear_active_reg ? clear_addr_reg : addr4_reg;
    assign mem_wdata = clear_active_reg ? '0 : inc4;
    assign mem_re    = v3_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            hist_mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rd_data_reg <= hist_mem[addr3_full[ADDR_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_active_reg <= 1'b1;
            clear_addr_reg   <= '0;
        end
        else if (clear_active_reg)
        begin
            if (clear_addr_reg == LAST_BIN)
                clear_active_reg <= 1'b0;
            else
                clear_addr_reg <= clear_addr_reg + 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Output queue
    // ------------------------------------------------------------------
    clh_pkg::out_item_t fifo_mem_reg [clh_pkg::FIFO_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    clh_pkg::out_item_t head;

    always_ff @(posedge clk)
    begin
        if (v4_reg)
            fifo_mem_reg[wr_ptr_reg] <= push_item;
    end

    always_comb
    begin
        fifo_count_next = fifo_count_reg;
        if (v4_reg && !out_fire)
            fifo_count_next = fifo_count_reg + 1'b1;
        else if (!v4_reg && out_fire)
            fifo_count_next = fifo_count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            fifo_count_reg <= '0;
            credit_reg     <= '0;
        end
        else
        begin
            if (v4_reg)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (out_fire)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            fifo_count_reg <= fifo_count_next;
            credit_reg     <= credit_next;
        end
    end

    assign head           = fifo_mem_reg[rd_ptr_reg];
    assign out_valid      = fifo_count_reg != '0;
    assign accepted       = head.accepted;
    assign abs_difference = head.abs_difference;
    assign binned         = head.binned;
    assign bin_index      = head.bin_index;
    assign bin_count      = head.bin_count;
    assign accepted_total = head.accepted_total;
    assign rejected_total = head.rejected_total;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // Credit tracks everything in the pipeline and the queue
    a_credit_match: assert property (@(posedge clk) disable iff (!rst_n)
        credit_reg == CREDIT_W'(v1_reg) + CREDIT_W'(v2_reg) + CREDIT_W'(v3_reg)
                      + CREDIT_W'(v4_reg) + fifo_count_reg)
        else $error("credit count out of step with transactions in flight");

    // Queue never overflows
    a_fifo_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        v4_reg && !out_fire |-> fifo_count_reg < FIFO_FULL)
        else $error("output queue overflow");

    // No transaction in flight while the histogram is being cleared
    a_clear_idle: assert property (@(posedge clk) disable iff (!rst_n)
        clear_active_reg |-> !v1_reg && !v2_reg && !v3_reg && !v4_reg
                             && fifo_count_reg == '0)
        else $error("transaction in flight during clearing pass");

    // A binned event always reports a nonzero count
    a_binned_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        v4_reg && push_item.binned |-> push_item.bin_count != '0)
        else $error("binned event with zero count");

    // Forwarded write data matches the last value written
    a_forward_data: assert property (@(posedge clk) disable iff (!rst_n)
        item_we |=> wr_valid_reg && wr_data_reg == $past(inc4))
        else $error("forwarding register lost the last write");

endmodule

[dv/clh_histogram_checker.sv]
`timescale 1ns / 1ps

// Watches both channels and the register port, predicts each result in order and
// compares it with what the block returns.
module clh_histogram_checker
    import clh_pkg::*;
#(
    parameter int NUM_BINS     = DEFAULT_NUM_BINS,
    parameter int BIN_WIDTH_PS = DEFAULT_BIN_WIDTH_PS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  logic                  kind,
    input  logic                  hit_a,
    input  logic                  hit_b,
    input  logic [ENERGY_W-1:0]   energy_a,
    input  logic [ENERGY_W-1:0]   energy_b,
    input  logic [TIME_W-1:0]     time_a,
    input  logic [TIME_W-1:0]     time_b,
    input  logic [SEL_W-1:0]      bin_select,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  logic                  accepted,
    input  logic [TIME_W-1:0]     abs_difference,
    input  logic                  binned,
    input  logic [SEL_W-1:0]      bin_index,
    input  logic [COUNT_W-1:0]    bin_count,
    input  logic [COUNT_W-1:0]    accepted_total,
    input  logic [COUNT_W-1:0]    rejected_total,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic                  pready,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output int                    mismatches,
    output int                    outstanding,
    output int                    checked
);

    // Shadow registers
    logic [ENERGY_W-1:0] a_lo, a_hi, b_lo, b_hi;
    logic [TIME_W-1:0]   coinc_window;
    logic [LIMIT_W-1:0]  hist_limit;

    // Predicted histogram and totals
    logic [COUNT_W-1:0]  lifetime_bins [NUM_BINS];
    logic [COUNT_W-1:0]  accept_cnt;
    logic [COUNT_W-1:0]  reject_cnt;

    out_item_t           pending_results [$];
    int                  err_cnt;
    int                  done_cnt;

    function automatic logic energy_ok(input logic [ENERGY_W-1:0] e);
        return ((e > a_lo) && (e < a_hi)) || ((e > b_lo) && (e < b_hi));
    endfunction

    // Result of one transaction; updates the predicted histogram and totals
    function automatic out_item_t predict_histogram_step(
        input logic                k,
        input logic                ha,
        input logic                hb,
        input logic [ENERGY_W-1:0] ea,
        input logic [ENERGY_W-1:0] eb,
        input logic [TIME_W-1:0]   ta,
        input logic [TIME_W-1:0]   tb,
        input logic [SEL_W-1:0]    sel
    );
        out_item_t         r;
        logic [TIME_W-1:0] dt;
        logic [TIME_W-1:0] slot;
        r = '0;
        if (k)
        begin
            // bin read, no state change
            r.bin_index = sel;
            if (sel < NUM_BINS)
                r.bin_count = lifetime_bins[sel];
        end
        else
        begin
            dt = (ta >= tb) ? ta - tb : tb - ta;
            r.abs_difference = dt;
            if (ha && hb && energy_ok(ea) && energy_ok(eb) && (dt < coinc_window))
            begin
                r.accepted = 1'b1;
                if (accept_cnt != '1)
                    accept_cnt = accept_cnt + 1'b1;
                if (dt < hist_limit)
                begin
                    slot = dt / BIN_WIDTH_PS;
                    // bins past the end are dropped silently
                    if (slot < NUM_BINS)
                    begin
                        if (lifetime_bins[slot] != '1)
                            lifetime_bins[slot] = lifetime_bins[slot] + 1'b1;
                        r.binned    = 1'b1;
                        r.bin_index = slot[SEL_W-1:0];
                        r.bin_count = lifetime_bins[slot];
                    end
                end
            end
            else if (reject_cnt != '1)
            begin
                reject_cnt = reject_cnt + 1'b1;
            end
        end
        r.accepted_total = accept_cnt;
        r.rejected_total = reject_cnt;
        return r;
    endfunction

    function automatic string describe(input out_item_t r);
        return $sformatf("acc=%0b diff=%0d binned=%0b bin=%0d count=%0d acc_tot=%0d rej_tot=%0d",
                         r.accepted, r.abs_difference, r.binned, r.bin_index,
                         r.bin_count, r.accepted_total, r.rejected_total);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t seen;
        out_item_t want;
        if (!rst_n)
        begin
            a_lo         = RST_WINDOW_A_LOW;
            a_hi         = RST_WINDOW_A_HIGH;
            b_lo         = RST_WINDOW_B_LOW;
            b_hi         = RST_WINDOW_B_HIGH;
            coinc_window = RST_TIME_WINDOW;
            hist_limit   = RST_HISTOGRAM_LIMIT;
            for (int i = 0; i < NUM_BINS; i++)
                lifetime_bins[i] = '0;
            accept_cnt = '0;
            reject_cnt = '0;
            pending_results.delete();
            err_cnt  = 0;
            done_cnt = 0;
        end
        else
        begin
            // Register write
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[APB_ADDR_W-1:3])
                    REG_WINDOW_A_LOW:    a_lo         = pwdata[ENERGY_W-1:0];
                    REG_WINDOW_A_HIGH:   a_hi         = pwdata[ENERGY_W-1:0];
                    REG_WINDOW_B_LOW:    b_lo         = pwdata[ENERGY_W-1:0];
                    REG_WINDOW_B_HIGH:   b_hi         = pwdata[ENERGY_W-1:0];
                    REG_TIME_WINDOW:     coinc_window = pwdata[TIME_W-1:0];
                    REG_HISTOGRAM_LIMIT: hist_limit   = pwdata[LIMIT_W-1:0];
                    default: ;
                endcase
            end

            // Result transaction against the oldest prediction
            if (out_valid && out_ready)
            begin
                seen = {accepted, abs_difference, binned, bin_index,
                        bin_count, accepted_total, rejected_total};
                if (pending_results.size() == 0)
                begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("%0t: result with nothing pending: %s", $time, describe(seen));
                end
                else
                begin
                    want = pending_results.pop_front();
                    done_cnt++;
                    if (seen !== want)
                    begin
                        err_cnt++;
                        if (err_cnt <= 10)
                        begin
                            $display("%0t: mismatch on result %0d", $time, done_cnt);
                            $display("  expected %s", describe(want));
                            $display("  actual   %s", describe(seen));
                        end
                    end
                end
            end

            // Input transaction
            if (in_valid && in_ready)
                pending_results.push_back(predict_histogram_step(kind, hit_a, hit_b,
                    energy_a, energy_b, time_a, time_b, bin_select));
        end
        mismatches  <= err_cnt;
        outstanding <= pending_results.size();
        checked     <= done_cnt;
    end

endmodule

[dv/tb_coincidence_lifetime_histogrammer.sv]
`timescale 1ns / 1ps

module tb_coincidence_lifetime_histogrammer;
    import clh_pkg::*;

    localparam int                NUM_PHASES  = 8;
    localparam int                PHASE_ITEMS = 215;
    localparam logic [TIME_W-1:0] TIME_MAX    = '1;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic                  kind = 1'b0;
    logic                  hit_a = 1'b0;
    logic                  hit_b = 1'b0;
    logic [ENERGY_W-1:0]   energy_a = '0;
    logic [ENERGY_W-1:0]   energy_b = '0;
    logic [TIME_W-1:0]     time_a = '0;
    logic [TIME_W-1:0]     time_b = '0;
    logic [SEL_W-1:0]      bin_select = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b1;
    logic                  accepted;
    logic [TIME_W-1:0]     abs_difference;
    logic                  binned;
    logic [SEL_W-1:0]      bin_index;
    logic [COUNT_W-1:0]    bin_count;
    logic [COUNT_W-1:0]    accepted_total;
    logic [COUNT_W-1:0]    rejected_total;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int                    mismatches;
    int                    outstanding;
    int                    checked;

    // Stimulus-side copy of the registers, used only to shape events
    logic [ENERGY_W-1:0]   cfg_a_lo = RST_WINDOW_A_LOW;
    logic [ENERGY_W-1:0]   cfg_a_hi = RST_WINDOW_A_HIGH;
    logic [ENERGY_W-1:0]   cfg_b_lo = RST_WINDOW_B_LOW;
    logic [ENERGY_W-1:0]   cfg_b_hi = RST_WINDOW_B_HIGH;
    logic [TIME_W-1:0]     cfg_window = RST_TIME_WINDOW;
    logic [LIMIT_W-1:0]    cfg_limit = RST_HISTOGRAM_LIMIT;

    int                    send_gap_pct = 0;
    int                    stall_pct = 0;
    int                    sent_items = 0;
    int                    settings_used = 1;

    coincidence_lifetime_histogrammer i_dut (.*);

    clh_histogram_checker i_checker (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receiver back-pressure
    always @(posedge clk)
        out_ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);

    initial
    begin
        #5000000;
        $display("Timeout with %0d results still pending", outstanding);
        $display("FAILED: results differ");
        $finish;
    end

    function automatic logic [TIME_W-1:0] rand_time();
        return TIME_W'({$urandom, $urandom});
    endfunction

    // Mostly inside one of the windows, sometimes anywhere
    function automatic logic [ENERGY_W-1:0] pick_energy();
        logic [ENERGY_W-1:0] lo, hi;
        if ($urandom_range(99) < 15)
            return ENERGY_W'($urandom);
        if ($urandom_range(1))
        begin
            lo = cfg_a_lo;
            hi = cfg_a_hi;
        end
        else
        begin
            lo = cfg_b_lo;
            hi = cfg_b_hi;
        end
        if (hi > lo + 1)
            return ENERGY_W'($urandom_range(hi - 1, lo + 1));
        return ENERGY_W'($urandom);
    endfunction

    // Time difference: few hot bins, binnable range, edges, coincident, anything
    function automatic logic [TIME_W-1:0] pick_gap();
        longint unsigned span;
        int unsigned     r;
        r = $urandom_range(99);
        if (r < 30)
            return TIME_W'($urandom_range(49));
        if (r < 60)
            return (cfg_limit == 0) ? '0 : TIME_W'($urandom_range(cfg_limit - 1));
        if (r < 66)
        begin
            case ($urandom_range(3))
                0: return TIME_W'(cfg_limit) - 1'b1;
                1: return TIME_W'(cfg_limit);
                2: return cfg_window - 1'b1;
                default: return cfg_window;
            endcase
        end
        if (r < 85 && cfg_window > cfg_limit)
        begin
            span = cfg_window - cfg_limit;
            return TIME_W'(cfg_limit + ({$urandom, $urandom} % span));
        end
        return rand_time();
    endfunction

    function automatic logic [SEL_W-1:0] pick_bin();
        int hi;
        hi = cfg_limit / DEFAULT_BIN_WIDTH_PS;
        if (hi > (1 << SEL_W) - 1)
            hi = (1 << SEL_W) - 1;
        case ($urandom_range(3))
            0: return SEL_W'($urandom_range(9));
            1, 2: return SEL_W'($urandom_range(hi));
            default: return SEL_W'($urandom);
        endcase
    endfunction

    // One transaction on the input channel, with optional idle cycles first
    task automatic push_txn(
        input logic                k,
        input logic                ha,
        input logic                hb,
        input logic [ENERGY_W-1:0] ea,
        input logic [ENERGY_W-1:0] eb,
        input logic [TIME_W-1:0]   ta,
        input logic [TIME_W-1:0]   tb,
        input logic [SEL_W-1:0]    sel
    );
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        kind       <= k;
        hit_a      <= ha;
        hit_b      <= hb;
        energy_a   <= ea;
        energy_b   <= eb;
        time_a     <= ta;
        time_b     <= tb;
        bin_select <= sel;
        in_valid   <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sent_items++;
    endtask

    task automatic push_event(
        input logic                ha,
        input logic                hb,
        input logic [ENERGY_W-1:0] ea,
        input logic [ENERGY_W-1:0] eb,
        input logic [TIME_W-1:0]   ta,
        input logic [TIME_W-1:0]   tb
    );
        push_txn(1'b0, ha, hb, ea, eb, ta, tb, SEL_W'($urandom));
    endtask

    task automatic push_read(input logic [SEL_W-1:0] sel);
        push_txn(1'b1, 1'($urandom), 1'($urandom), ENERGY_W'($urandom), ENERGY_W'($urandom),
                 rand_time(), rand_time(), sel);
    endtask

    task automatic push_random();
        logic [TIME_W-1:0] ta, tb, dt;
        int unsigned       r;
        r = $urandom_range(99);
        if (r < 15)
        begin
            push_read(pick_bin());
        end
        else if (r < 25)
        begin
            // noise
            push_event(1'($urandom), 1'($urandom), ENERGY_W'($urandom), ENERGY_W'($urandom),
                       rand_time(), rand_time());
        end
        else
        begin
            dt = pick_gap();
            ta = rand_time();
            if ({1'b0, ta} + dt <= {1'b0, TIME_MAX})
                tb = ta + dt;
            else
                tb = ta - dt;
            if ($urandom_range(1))
            begin
                dt = ta;
                ta = tb;
                tb = dt;
            end
            if ($urandom_range(99) < 5)
                push_event(1'($urandom), 1'($urandom), pick_energy(), pick_energy(), ta, tb);
            else
                push_event(1'b1, 1'b1, pick_energy(), pick_energy(), ta, tb);
        end
    endtask

    // Setup and access phases, then idle before the next write
    task automatic write_reg(input logic [2:0] idx, input logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_WINDOW_A_LOW:    cfg_a_lo   = value[ENERGY_W-1:0];
            REG_WINDOW_A_HIGH:   cfg_a_hi   = value[ENERGY_W-1:0];
            REG_WINDOW_B_LOW:    cfg_b_lo   = value[ENERGY_W-1:0];
            REG_WINDOW_B_HIGH:   cfg_b_hi   = value[ENERGY_W-1:0];
            REG_TIME_WINDOW:     cfg_window = value[TIME_W-1:0];
            REG_HISTOGRAM_LIMIT: cfg_limit  = value[LIMIT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_setting(
        input logic [ENERGY_W-1:0] a_lo,
        input logic [ENERGY_W-1:0] a_hi,
        input logic [ENERGY_W-1:0] b_lo,
        input logic [ENERGY_W-1:0] b_hi,
        input logic [TIME_W-1:0]   tw,
        input logic [LIMIT_W-1:0]  lim
    );
        write_reg(REG_WINDOW_A_LOW, APB_DATA_W'(a_lo));
        write_reg(REG_WINDOW_A_HIGH, APB_DATA_W'(a_hi));
        write_reg(REG_WINDOW_B_LOW, APB_DATA_W'(b_lo));
        write_reg(REG_WINDOW_B_HIGH, APB_DATA_W'(b_hi));
        write_reg(REG_TIME_WINDOW, APB_DATA_W'(tw));
        write_reg(REG_HISTOGRAM_LIMIT, APB_DATA_W'(lim));
        settings_used++;
    endtask

    task automatic set_idle(input idle_mode_e mode);
        case (mode)
            IDLE_SENDER:   begin send_gap_pct = 47; stall_pct = 0;  end
            IDLE_RECEIVER: begin send_gap_pct = 0;  stall_pct = 47; end
            IDLE_BOTH:     begin send_gap_pct = 33; stall_pct = 33; end
            default:       begin send_gap_pct = 0;  stall_pct = 0;  end
        endcase
    endtask

    // Stop sending and wait for every pending result
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    initial
    begin
        logic [ENERGY_W-1:0] a_lo, b_lo;
        logic [TIME_W-1:0]   tw;
        logic [LIMIT_W-1:0]  lim;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed pass at reset settings: windows 180..390 and 660..1100,
        // coincidence 200000 ps, histogram limit 50000 ps
        set_idle(IDLE_NONE);
        push_read('0);
        push_read('1);
        push_event(1'b1, 1'b1, 12'd181, 12'd1099, 40'd1000, 40'd1000);
        push_event(1'b1, 1'b1, 12'd389, 12'd661, TIME_MAX, TIME_MAX - 40'd4);
        push_event(1'b1, 1'b1, 12'd389, 12'd661, 40'd0, 40'd49999);
        push_event(1'b1, 1'b1, 12'd200, 12'd700, 40'd50000, 40'd0);
        push_event(1'b1, 1'b1, 12'd200, 12'd700, 40'd0, 40'd199999);
        push_event(1'b1, 1'b1, 12'd200, 12'd700, 40'd200000, 40'd0);
        push_event(1'b1, 1'b1, 12'd180, 12'd700, 40'd7, 40'd9);
        push_event(1'b1, 1'b1, 12'd390, 12'd700, 40'd7, 40'd9);
        push_event(1'b1, 1'b1, 12'd300, 12'd660, 40'd7, 40'd9);
        push_event(1'b1, 1'b1, 12'd300, 12'd1100, 40'd7, 40'd9);
        push_event(1'b1, 1'b1, 12'd0, 12'd4095, 40'd7, 40'd9);
        // missing hits still report the difference
        push_event(1'b0, 1'b1, 12'd300, 12'd700, 40'd5, 40'd12);
        push_event(1'b1, 1'b0, 12'd300, 12'd700, 40'd12, 40'd5);
        push_event(1'b0, 1'b0, 12'd300, 12'd700, 40'd5, 40'd5);
        push_event(1'b1, 1'b1, 12'd300, 12'd700, TIME_MAX, 40'd0);
        push_event(1'b1, 1'b1, 12'd300, 12'd700, 40'd0, TIME_MAX);
        // same bin back to back
        push_event(1'b1, 1'b1, 12'd300, 12'd700, 40'd100, 40'd107);
        push_event(1'b1, 1'b1, 12'd300, 12'd700, 40'd109, 40'd100);
        push_read(14'd0);
        push_read(14'd1);
        push_read(14'd9999);
        drain_results();

        // Randomized phases, each under its own register setting
        for (int p = 1; p <= NUM_PHASES; p++)
        begin
            case (p)
                1: apply_setting(12'd100, 12'd500, 12'd600, 12'd1500, 40'd100000, 17'd81920);
                2: apply_setting(12'd0, 12'd4095, 12'd0, 12'd4095, TIME_MAX, 17'd1);
                3: apply_setting(12'd4095, 12'd0, 12'd4095, 12'd0, 40'd0, 17'd0);
                default:
                begin
                    a_lo = ENERGY_W'($urandom_range(1000));
                    b_lo = ENERGY_W'($urandom_range(2500, 500));
                    tw   = $urandom_range(1) ? TIME_W'($urandom_range(300000, 1000))
                                             : rand_time();
                    // beyond the last bin in phase 4
                    lim  = (p == 4) ? '1 : LIMIT_W'($urandom_range(81920));
                    apply_setting(a_lo, a_lo + ENERGY_W'($urandom_range(800, 1)),
                                  b_lo, b_lo + ENERGY_W'($urandom_range(1500, 1)), tw, lim);
                end
            endcase
            set_idle(idle_mode_e'((p - 1) % 4));
            for (int n = 0; n < PHASE_ITEMS; n++)
                push_random();
            drain_results();
        end

        set_idle(IDLE_NONE);
        repeat (10) @(posedge clk);
        $display("Sent %0d transactions (events and bin reads) under %0d register settings,",
                 sent_items, settings_used);
        $display("with sender gaps and receiver stalls; %0d results compared.", checked);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

[files.f]
rtl/clh_pkg.sv
rtl/coincidence_lifetime_histogrammer.sv
dv/clh_histogram_checker.sv
dv/tb_coincidence_lifetime_histogrammer.sv
